FILE: design/kwm_pkg.sv
`default_nettype none

package kwm_pkg;

    localparam int LANES_DEF      = 8;
    localparam int STAMP_BITS_DEF = 64;

    localparam int LANE_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int STAMP_W   = 64;
    localparam int ORIGIN_W  = 8;
    localparam int PAYLOAD_W = 64;
    localparam int TDATA_W   = STAMP_W + ORIGIN_W + PAYLOAD_W;
    localparam int TUSER_W   = LANE_W + 1;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LANES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAP   = 4'd1;

    localparam logic [COUNT_W-1:0]    ACTIVE_RST  = 4'd8;
    localparam logic [CFG_DATA_W-1:0] MAP_RST     = 64'h0706050403020100;
    localparam logic [ORIGIN_W-1:0]   KEEP_ORIGIN = 8'hFF;

    typedef enum logic [1:0] {
        LS_PENDING   = 2'd0,
        LS_FULL      = 2'd1,
        LS_EXHAUSTED = 2'd2
    } t_lane_st;

    typedef struct packed {
        logic take;
        logic settled;
        logic any_full;
    } t_bank_stat;

endpackage

`default_nettype wire

FILE: design/kwm_min_tree.sv
`default_nettype none

module kwm_min_tree #(
    parameter int LANES      = kwm_pkg::LANES_DEF,
    parameter int STAMP_BITS = kwm_pkg::STAMP_BITS_DEF
) (
    input  wire logic                         i_cand   [LANES],
    input  wire logic [STAMP_BITS-1:0]        i_stamp  [LANES],
    input  wire logic [kwm_pkg::ORIGIN_W-1:0] i_origin [LANES],
    output logic                              o_vld,
    output logic [$clog2(LANES)-1:0]          o_lane
);
    import kwm_pkg::*;

    localparam int LW     = $clog2(LANES);
    localparam int LEAVES = 1 << LW;
    localparam int NODES  = 2 * LEAVES;

    logic                  w_vld  [1:NODES-1];
    logic [STAMP_BITS-1:0] w_stmp [1:NODES-1];
    logic [ORIGIN_W-1:0]   w_org  [1:NODES-1];
    logic [LW-1:0]         w_lane [1:NODES-1];

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++) begin : g_leaf
            if (g < LANES) begin : g_real
                assign w_vld[LEAVES+g]  = i_cand[g];
                assign w_stmp[LEAVES+g] = i_stamp[g];
                assign w_org[LEAVES+g]  = i_origin[g];
            end else begin : g_pad
                assign w_vld[LEAVES+g]  = 1'b0;
                assign w_stmp[LEAVES+g] = '0;
                assign w_org[LEAVES+g]  = '0;
            end
            assign w_lane[LEAVES+g] = LW'(g);
        end

        // left child always holds the lower lanes, so it wins full ties
        for (g = 1; g < LEAVES; g++) begin : g_node
            logic w_right;
            assign w_right = w_vld[2*g+1] && (!w_vld[2*g] ||
                             (w_stmp[2*g+1] < w_stmp[2*g]) ||
                             ((w_stmp[2*g+1] == w_stmp[2*g]) && (w_org[2*g+1] < w_org[2*g])));
            assign w_vld[g]  = w_vld[2*g] || w_vld[2*g+1];
            assign w_stmp[g] = w_right ? w_stmp[2*g+1] : w_stmp[2*g];
            assign w_org[g]  = w_right ? w_org[2*g+1]  : w_org[2*g];
            assign w_lane[g] = w_right ? w_lane[2*g+1] : w_lane[2*g];
        end
    endgenerate

    assign o_vld  = w_vld[1];
    assign o_lane = w_lane[1];

endmodule

`default_nettype wire

FILE: design/kwm_lane_bank.sv
`default_nettype none

module kwm_lane_bank #(
    parameter int LANES      = kwm_pkg::LANES_DEF,
    parameter int STAMP_BITS = kwm_pkg::STAMP_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_item_vld,
    input  wire logic [kwm_pkg::LANE_W-1:0]    i_lane,
    input  wire logic                          i_exh,
    input  wire logic [STAMP_BITS-1:0]         i_stamp,
    input  wire logic [kwm_pkg::ORIGIN_W-1:0]  i_origin,
    input  wire logic [kwm_pkg::PAYLOAD_W-1:0] i_payload,
    input  wire logic [kwm_pkg::COUNT_W-1:0]   i_count,
    input  wire logic                          i_pop,
    input  wire logic [$clog2(LANES)-1:0]      i_pop_lane,
    output kwm_pkg::t_bank_stat                o_stat,
    output logic                               o_cand        [LANES],
    output logic [STAMP_BITS-1:0]              o_eff_stamp   [LANES],
    output logic [kwm_pkg::ORIGIN_W-1:0]       o_eff_origin  [LANES],
    output logic [kwm_pkg::PAYLOAD_W-1:0]      o_eff_payload [LANES]
);
    import kwm_pkg::*;

    localparam int LW = $clog2(LANES);

    t_lane_st              r_st      [LANES];
    logic [STAMP_BITS-1:0] r_stamp   [LANES];
    logic [ORIGIN_W-1:0]   r_origin  [LANES];
    logic [PAYLOAD_W-1:0]  r_payload [LANES];

    t_lane_st w_st  [LANES];
    logic     w_hit [LANES];
    logic     w_wr  [LANES];
    logic     w_act [LANES];
    logic     w_hit_pending;
    logic     w_take;
    logic     w_settled;
    logic     w_any_full;

    always_comb begin
        w_hit_pending = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            w_hit[i] = (i_lane == LANE_W'(i));
            w_act[i] = (COUNT_W'(i) < i_count);
            if (w_hit[i] && r_st[i] == LS_PENDING) begin
                w_hit_pending = 1'b1;
            end
        end
    end

    assign w_take = i_item_vld && ({1'b0, i_lane} < i_count) && w_hit_pending;

    always_comb begin
        w_settled  = 1'b1;
        w_any_full = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            w_wr[i] = w_take && w_hit[i] && !i_exh;
            if (w_take && w_hit[i]) begin
                w_st[i] = i_exh ? LS_EXHAUSTED : LS_FULL;
            end else begin
                w_st[i] = r_st[i];
            end
            o_cand[i]        = w_act[i] && (w_st[i] == LS_FULL);
            o_eff_stamp[i]   = w_wr[i] ? i_stamp   : r_stamp[i];
            o_eff_origin[i]  = w_wr[i] ? i_origin  : r_origin[i];
            o_eff_payload[i] = w_wr[i] ? i_payload : r_payload[i];
            if (w_act[i] && w_st[i] == LS_PENDING) begin
                w_settled = 1'b0;
            end
            if (o_cand[i]) begin
                w_any_full = 1'b1;
            end
        end
    end

    assign o_stat.take     = w_take;
    assign o_stat.settled  = w_settled;
    assign o_stat.any_full = w_any_full;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LANES; i++) begin
            if (!i_rst_n) begin
                r_st[i] <= LS_PENDING;
            end else if (i_pop && i_pop_lane == LW'(i)) begin
                r_st[i] <= LS_PENDING;
            end else begin
                r_st[i] <= w_st[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LANES; i++) begin
            if (w_wr[i]) begin
                r_stamp[i]   <= i_stamp;
                r_origin[i]  <= i_origin;
                r_payload[i] <= i_payload;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/k_way_sorted_stream_merge_top.sv
`default_nettype none

// Channel   Direction  Handshake                      Content
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready lane record or end mark
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready merged record or done
// cfg       in         i_cfg_valid/o_cfg_ready         register index and data
//
// One item per cycle while the result register is empty or drained; results pass input then result register.
// The critical path is the lane head update plus the log2(LANES) level min tree.
// Synchronous active-low reset marks every lane pending; heads are not reset.
// Input register frees whenever the result register is empty or being drained.

module k_way_sorted_stream_merge_top #(
    parameter int LANES      = kwm_pkg::LANES_DEF,
    parameter int STAMP_BITS = kwm_pkg::STAMP_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [63:0] stamp, [71:64] origin_id, [135:72] payload
    input  wire logic [kwm_pkg::TDATA_W-1:0]    i_s_axis_tdata,
    // [2:0] lane, [3] exhausted
    input  wire logic [kwm_pkg::TUSER_W-1:0]    i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [63:0] out_stamp, [71:64] out_origin, [135:72] out_payload
    output logic [kwm_pkg::TDATA_W-1:0]         o_m_axis_tdata,
    // [2:0] refill_lane, [3] done_res
    output logic [kwm_pkg::TUSER_W-1:0]         o_m_axis_tuser,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [kwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [kwm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kwm_pkg::*;

    localparam int LW = $clog2(LANES);

    logic [COUNT_W-1:0]    r_active;
    logic [CFG_DATA_W-1:0] r_map;

    logic                  r_in_valid;
    logic [LANE_W-1:0]     r_in_lane;
    logic                  r_in_exh;
    logic [STAMP_BITS-1:0] r_in_stamp;
    logic [ORIGIN_W-1:0]   r_in_origin;
    logic [PAYLOAD_W-1:0]  r_in_payload;

    logic                  r_out_valid;
    logic [STAMP_BITS-1:0] r_out_stamp;
    logic [ORIGIN_W-1:0]   r_out_origin;
    logic [PAYLOAD_W-1:0]  r_out_payload;
    logic [LANE_W-1:0]     r_out_refill;
    logic                  r_out_done;

    logic                  w_proc;
    logic                  w_emit;
    logic                  w_pop;
    logic [COUNT_W-1:0]    w_count;
    logic [ORIGIN_W-1:0]   w_map_byte;
    logic [ORIGIN_W-1:0]   w_origin;
    t_bank_stat            w_stat;
    logic                  w_cand        [LANES];
    logic [STAMP_BITS-1:0] w_eff_stamp   [LANES];
    logic [ORIGIN_W-1:0]   w_eff_origin  [LANES];
    logic [PAYLOAD_W-1:0]  w_eff_payload [LANES];
    logic                  w_win_vld;
    logic [LW-1:0]         w_win_lane;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST;
            r_map    <= MAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACTIVE_LANES: r_active <= i_cfg_data[COUNT_W-1:0];
                CFG_SOURCE_MAP:   r_map    <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb begin
        if (r_active == '0) begin
            w_count = COUNT_W'(1);
        end else if (r_active > COUNT_W'(LANES)) begin
            w_count = COUNT_W'(LANES);
        end else begin
            w_count = r_active;
        end
    end

    // input register
    assign w_proc          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_lane    <= i_s_axis_tuser[LANE_W-1:0];
            r_in_exh     <= i_s_axis_tuser[LANE_W];
            r_in_stamp   <= i_s_axis_tdata[STAMP_BITS-1:0];
            r_in_origin  <= i_s_axis_tdata[STAMP_W +: ORIGIN_W];
            r_in_payload <= i_s_axis_tdata[STAMP_W+ORIGIN_W +: PAYLOAD_W];
        end
    end

    assign w_map_byte = r_map[{r_in_lane, 3'd0} +: ORIGIN_W];
    assign w_origin   = (w_map_byte != KEEP_ORIGIN) ? w_map_byte : r_in_origin;

    kwm_lane_bank #(
        .LANES      (LANES),
        .STAMP_BITS (STAMP_BITS)
    ) u_bank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_vld    (w_proc),
        .i_lane        (r_in_lane),
        .i_exh         (r_in_exh),
        .i_stamp       (r_in_stamp),
        .i_origin      (w_origin),
        .i_payload     (r_in_payload),
        .i_count       (w_count),
        .i_pop         (w_pop),
        .i_pop_lane    (w_win_lane),
        .o_stat        (w_stat),
        .o_cand        (w_cand),
        .o_eff_stamp   (w_eff_stamp),
        .o_eff_origin  (w_eff_origin),
        .o_eff_payload (w_eff_payload)
    );

    kwm_min_tree #(
        .LANES      (LANES),
        .STAMP_BITS (STAMP_BITS)
    ) u_tree (
        .i_cand   (w_cand),
        .i_stamp  (w_eff_stamp),
        .i_origin (w_eff_origin),
        .o_vld    (w_win_vld),
        .o_lane   (w_win_lane)
    );

    assign w_emit = w_proc && w_stat.take && w_stat.settled;
    assign w_pop  = w_emit && w_stat.any_full;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= w_emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (w_stat.any_full) begin
                r_out_stamp   <= w_eff_stamp[w_win_lane];
                r_out_origin  <= w_eff_origin[w_win_lane];
                r_out_payload <= w_eff_payload[w_win_lane];
                r_out_refill  <= LANE_W'(w_win_lane);
                r_out_done    <= 1'b0;
            end else begin
                r_out_stamp   <= '0;
                r_out_origin  <= '0;
                r_out_payload <= '0;
                r_out_refill  <= '0;
                r_out_done    <= 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_payload, r_out_origin, STAMP_W'(r_out_stamp)};
    assign o_m_axis_tuser  = {r_out_done, r_out_refill};

    a_no_take_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && !w_stat.take |=> !r_out_valid)
        else $error("result produced for an ignored item");

    a_done_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_out_stamp == '0 && r_out_refill == '0)
        else $error("done result carries record fields");

    a_winner_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_win_vld)
        else $error("record emitted without a winning lane");

endmodule

`default_nettype wire

FILE: bench/k_way_sorted_stream_merge_top_tb.sv
`timescale 1ns / 100ps

module k_way_sorted_stream_merge_top_tb;
    import kwm_pkg::*;

    localparam int NUM_LANES = LANES_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic [STAMP_W-1:0]   stamp;
        logic [ORIGIN_W-1:0]  origin;
        logic [PAYLOAD_W-1:0] payload;
        logic [LANE_W-1:0]    refill;
        logic                 done;
    } merged_rec_t;

    class merge_tracker;
        t_lane_st              lane_st[NUM_LANES];
        logic [STAMP_W-1:0]    head_stamp[NUM_LANES];
        logic [ORIGIN_W-1:0]   head_origin[NUM_LANES];
        logic [PAYLOAD_W-1:0]  head_payload[NUM_LANES];
        logic [COUNT_W-1:0]    active_reg;
        logic [CFG_DATA_W-1:0] map_reg;
        merged_rec_t           merged_q[$];
        int                    errors;

        function new();
            active_reg = ACTIVE_RST;
            map_reg = MAP_RST;
            errors = 0;
            foreach (lane_st[i]) lane_st[i] = LS_PENDING;
        endfunction

        function int lanes_in_use();
            if (active_reg == 0) return 1;
            if (active_reg > NUM_LANES) return NUM_LANES;
            return int'(active_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ACTIVE_LANES) active_reg = data[COUNT_W-1:0];
            else if (idx == CFG_SOURCE_MAP) map_reg = data;
        endfunction

        function bit takes(int lane);
            return lane < lanes_in_use() && lane_st[lane] == LS_PENDING;
        endfunction

        function bit finished();
            for (int i = 0; i < lanes_in_use(); i++)
                if (lane_st[i] != LS_EXHAUSTED) return 0;
            return 1;
        endfunction

        function bit ahead(int a, int b);
            if (head_stamp[a] != head_stamp[b]) return head_stamp[a] < head_stamp[b];
            if (head_origin[a] != head_origin[b]) return head_origin[a] < head_origin[b];
            return a < b;
        endfunction

        // returns 1 when the transfer changed lane state
        function bit note_item(logic [LANE_W-1:0] lane, logic exh, logic [STAMP_W-1:0] stamp,
                               logic [ORIGIN_W-1:0] origin, logic [PAYLOAD_W-1:0] payload);
            int n;
            int l;
            int best;
            bit any_full;
            logic [ORIGIN_W-1:0] mapped;
            merged_rec_t rec;
            n = lanes_in_use();
            l = int'(lane);
            if (!takes(l)) return 0;
            if (exh) begin
                lane_st[l] = LS_EXHAUSTED;
            end else begin
                mapped = map_reg[l*ORIGIN_W +: ORIGIN_W];
                head_stamp[l] = stamp;
                head_origin[l] = (mapped != KEEP_ORIGIN) ? mapped : origin;
                head_payload[l] = payload;
                lane_st[l] = LS_FULL;
            end
            best = 0;
            any_full = 0;
            for (int i = 0; i < n; i++) begin
                if (lane_st[i] == LS_PENDING) return 1;
                if (lane_st[i] == LS_FULL) begin
                    if (!any_full || ahead(i, best)) best = i;
                    any_full = 1;
                end
            end
            if (!any_full) begin
                rec = '{stamp: '0, origin: '0, payload: '0, refill: '0, done: 1'b1};
            end else begin
                rec = '{stamp: head_stamp[best], origin: head_origin[best],
                        payload: head_payload[best], refill: LANE_W'(best), done: 1'b0};
                lane_st[best] = LS_PENDING;
            end
            merged_q.insert(merged_q.size(), rec);
            return 1;
        endfunction

        function void match(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [TDATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser);
            merged_rec_t want;
            if (merged_q.size() == 0) begin
                $error("unexpected output transfer: tdata %h tuser %h", tdata, tuser);
                errors++;
                return;
            end
            want = merged_q.pop_front();
            match("out_stamp", want.stamp, tdata[STAMP_W-1:0]);
            match("out_origin", want.origin, tdata[STAMP_W +: ORIGIN_W]);
            match("out_payload", want.payload, tdata[STAMP_W+ORIGIN_W +: PAYLOAD_W]);
            match("refill_lane", want.refill, tuser[LANE_W-1:0]);
            match("done_res", want.done, tuser[LANE_W]);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [TDATA_W-1:0]    i_s_axis_tdata = '0;
    logic [TUSER_W-1:0]    i_s_axis_tuser = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    wire                   o_s_axis_tready;
    wire                   o_m_axis_tvalid;
    wire [TDATA_W-1:0]     o_m_axis_tdata;
    wire [TUSER_W-1:0]     o_m_axis_tuser;
    wire                   o_cfg_ready;

    merge_tracker       sb;
    logic [STAMP_W-1:0] lane_stamp[NUM_LANES];
    int                 send_quiet = 0;
    int                 recv_quiet = 0;
    bit                 hold_request = 0;

    k_way_sorted_stream_merge_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // bursts of back-to-back transfers between stretches of random gaps
    function automatic int idle_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) quiet = $urandom_range(20, 40);
        return $urandom_range(0, 5);
    endfunction

    task automatic push_record(logic [LANE_W-1:0] lane, logic exh, logic [STAMP_W-1:0] stamp,
                               logic [ORIGIN_W-1:0] origin, logic [PAYLOAD_W-1:0] payload,
                               output bit taken);
        int gap;
        gap = idle_gap(send_quiet);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {payload, origin, stamp};
        i_s_axis_tuser <= {exh, lane};
        do @(posedge i_clk); while (!o_s_axis_tready);
        taken = sb.note_item(lane, exh, stamp, origin, payload);
    endtask

    // mostly the next record of a waiting lane; the rest is noise
    task automatic push_random(bit drain, output bit taken);
        int pend[$];
        int lane;
        logic exh;
        logic [STAMP_W-1:0] stamp;
        logic [ORIGIN_W-1:0] origin;
        logic [PAYLOAD_W-1:0] payload;
        for (int i = 0; i < NUM_LANES; i++)
            if (sb.takes(i)) pend.insert(pend.size(), i);
        payload = {$urandom, $urandom};
        origin = ORIGIN_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 254));
        if (pend.size() > 0 && (drain || $urandom_range(0, 7) != 0)) begin
            lane = pend[$urandom_range(0, pend.size() - 1)];
            exh = drain;
            if ($urandom_range(0, 7) == 0)
                lane_stamp[lane] += {$urandom, $urandom} >> $urandom_range(8, 63);
            else
                lane_stamp[lane] += STAMP_W'($urandom_range(0, 3));
            stamp = drain ? {$urandom, $urandom} : lane_stamp[lane];
        end else begin
            lane = $urandom_range(0, NUM_LANES - 1);
            exh = sb.takes(lane) ? 1'b0 : 1'($urandom_range(0, 1));
            stamp = {$urandom, $urandom};
        end
        push_record(LANE_W'(lane), exh, stamp, origin, payload, taken);
    endtask

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic write_regs(logic [COUNT_W-1:0] act, logic [CFG_DATA_W-1:0] map);
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        cfg_put(CFG_ACTIVE_LANES, {junk[CFG_DATA_W-1:COUNT_W], act});
        cfg_put(CFG_SOURCE_MAP, map);
        cfg_put(CFG_IDX_W'($urandom_range(CFG_SOURCE_MAP + 1, CFG_IDX_MAX)), junk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.merged_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [COUNT_W-1:0] act, logic [CFG_DATA_W-1:0] map, int items,
                             bit squeeze);
        int used;
        bit taken;
        settle();
        write_regs(act, map);
        foreach (lane_stamp[i]) lane_stamp[i] = {$urandom, $urandom} >> $urandom_range(1, 40);
        if (squeeze) hold_request = 1;
        used = 0;
        while (used < items) begin
            push_random(0, taken);
            used += taken;
        end
    endtask

    initial begin
        bit taken;
        logic [CFG_DATA_W-1:0] scatter_map;
        logic [STAMP_W-1:0] top;
        top = '1;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two lanes: lane 0 mapped to source 5, lane 1 keeps the record's origin
        write_regs(4'd2, 64'h0706_0504_0302_FF05);
        push_record(0, 0, 0, 0, '0, taken);
        push_record(0, 0, 1, 1, 1, taken);
        push_record(5, 0, 2, 2, 2, taken);
        push_record(7, 1, top, 254, '1, taken);
        push_record(1, 0, 0, 254, '1, taken);
        push_record(0, 0, 0, 1, 64'hA5A5_A5A5_A5A5_A5A5, taken);
        push_record(0, 0, 10, 0, 64'h1, taken);
        push_record(1, 0, 10, 5, 64'h2, taken);
        push_record(1, 0, 12, 9, 64'h3, taken);
        push_record(0, 0, 11, 200, 64'h4, taken);
        push_record(1, 0, 11, 3, 64'h5, taken);
        push_record(1, 0, top, 0, 64'h5555_5555_5555_5555, taken);
        push_record(0, 0, top, 77, 64'h8000_0000_0000_0001, taken);
        push_record(1, 0, top, 254, '1, taken);

        // single lane (count 0 reads as 1), then its end mark gives done
        run_phase(4'd0, '1, 30, 0);
        push_record(0, 1, {$urandom, $urandom}, 8'd99, {$urandom, $urandom}, taken);
        push_record(0, 0, 5, 5, 5, taken);
        push_record(3, 1, 6, 6, 6, taken);

        run_phase(4'd8, '0, 150, 0);

        for (int b = 0; b < NUM_LANES; b++)
            scatter_map[b*ORIGIN_W +: ORIGIN_W] =
                ($urandom_range(0, 2) == 0) ? KEEP_ORIGIN : ORIGIN_W'($urandom);
        run_phase(4'd15, scatter_map, 150, 1);

        run_phase(4'd8, MAP_RST, 120, 0);
        while (!sb.finished()) push_random(1, taken);
        repeat (4) push_random(0, taken);

        settle();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                gap = LONG_HOLD;
            end else begin
                gap = idle_gap(recv_quiet);
            end
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
design/kwm_pkg.sv
design/kwm_min_tree.sv
design/kwm_lane_bank.sv
design/k_way_sorted_stream_merge_top.sv
bench/k_way_sorted_stream_merge_top_tb.sv
